[sv/arithmetic_range_encoder_assert.svh]
// assertion macros for the arithmetic range encoder
`ifndef ARITHMETIC_RANGE_ENCODER_ASSERT_SVH
`define ARITHMETIC_RANGE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

`define ARE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`define ARE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`else

`define ARE_ASSERT_IMP(name, clk, rst, ante, cons)

`define ARE_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

[sv/are_pkg.sv]
// shared types and constants of the arithmetic range encoder
`default_nettype none

package are_pkg;

   localparam int SCALE_W    = 14;
   localparam int COUNT_W    = 14;
   localparam int CODE_W     = 16;
   localparam int FOLLOW_W   = 16;
   localparam int RANGE_W    = CODE_W + 1;
   localparam int DIVIDEND_W = 30;
   localparam int REM_W      = SCALE_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = 5;

   localparam int CODE_MSB  = CODE_W - 1;
   localparam int UNDER_BIT = CODE_W - 2;

   localparam logic [SCALE_W-1:0]  SCALE_RESET = 14'h3fff;
   localparam logic [CODE_W-1:0]   LOW_RESET   = 16'h0000;
   localparam logic [CODE_W-1:0]   HIGH_RESET  = 16'hffff;
   localparam logic [FOLLOW_W-1:0] FOLLOW_MAX  = 16'hffff;
   localparam logic [CODE_W-1:0]   UNDER_MASK  = 16'h4000;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_UPD  = 5'b00100,
      ST_REN  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   typedef struct packed {
      logic mul_load;
      logic div_step;
      logic bounds_load;
      logic ren_step;
      logic flush_load;
      logic out_push;
      logic out_last;
   } cmd_type;

   typedef struct packed {
      logic scale_zero;
      logic div_last;
      logic ren_emit;
      logic ren_under;
      logic hold_valid;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[sv/arithmetic_range_encoder.sv]
// top level of the 16-bit arithmetic range encoder
// The encoder takes one word at a time. An encode word narrows the coding
// interval by its cumulative counts over the total scale held in the csr
// register and then renormalizes, giving up to sixteen result words, each a
// code bit plus the number of inverted copies that follow it; rsp_last marks
// the final word of an input. An encode word passes through a multiply, the
// two bit-serial dividers run side by side, one bound update, then one
// renormalization shift at a time, which waits while the hold and output
// registers are full, and a closing state. A flush word loads its result and
// closes. An encode word with a zero scale is dropped. The next word is
// accepted once the last result of the previous one has moved into the output
// register.
`default_nettype none

`include "arithmetic_range_encoder_assert.svh"

module arithmetic_range_encoder
   import are_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [SCALE_W-1:0]  csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_kind,
   input  wire logic [COUNT_W-1:0]  req_low_count,
   input  wire logic [COUNT_W-1:0]  req_high_count,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_code_bit,
   output logic [FOLLOW_W-1:0]      rsp_follow_count,
   output logic                     rsp_last
);

   cmd_type    ctl_cmd;
   status_type dp_status;

   are_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   are_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_low_count    (req_low_count),
      .req_high_count   (req_high_count),
      .cmd              (ctl_cmd),
      .status           (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_bit     (rsp_code_bit),
      .rsp_follow_count (rsp_follow_count),
      .rsp_last         (rsp_last)
   );

   // result moves to the output register only when it has room
   `ARE_ASSERT_IMP(a_push_free, clock, reset, ctl_cmd.out_push, dp_status.out_free)

   // hold stage is empty whenever a new word can come in
   `ARE_ASSERT_IMP(a_idle_empty, clock, reset, req_ready, !dp_status.hold_valid)

   // a flush word always leaves a result in the hold stage
   `ARE_ASSERT_NXT(a_flush_hold, clock, reset,
      req_valid && req_ready && req_kind == KIND_FLUSH, dp_status.hold_valid)

   // the last divider step is followed by the bound update
   `ARE_ASSERT_NXT(a_div_upd, clock, reset,
      ctl_cmd.div_step && dp_status.div_last, ctl_cmd.bounds_load)

endmodule

`default_nettype wire

[sv/are_ctrl.sv]
// controller state machine of the arithmetic range encoder
`default_nettype none

module are_ctrl
   import are_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_FLUSH) begin
                  cmd.flush_load = 1'b1;
                  state_in       = ST_FIN;
               end else if (!status.scale_zero) begin
                  cmd.mul_load = 1'b1;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.bounds_load = 1'b1;
            state_in        = ST_REN;
         end
         ST_REN: begin
            if (status.ren_emit) begin
               if (!status.hold_valid || status.out_free) begin
                  cmd.ren_step = 1'b1;
                  cmd.out_push = status.hold_valid;
               end
            end else if (status.ren_under) begin
               cmd.ren_step = 1'b1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!status.hold_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.out_push = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[sv/are_dpath.sv]
// datapath: bounds, pending count, serial dividers and result registers
`default_nettype none

module are_dpath
   import are_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [SCALE_W-1:0]  csr_write_data,
   input  wire logic [COUNT_W-1:0]  req_low_count,
   input  wire logic [COUNT_W-1:0]  req_high_count,
   input  wire cmd_type             cmd,
   output status_type               status,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_code_bit,
   output logic [FOLLOW_W-1:0]      rsp_follow_count,
   output logic                     rsp_last
);

   logic [SCALE_W-1:0]    scale_ff, scale_in;
   logic [CODE_W-1:0]     low_ff, low_in;
   logic [CODE_W-1:0]     high_ff, high_in;
   logic [FOLLOW_W-1:0]   pend_ff, pend_in;
   logic [DIVIDEND_W-1:0] dq_h_ff, dq_h_in, dq_l_ff, dq_l_in;
   logic [REM_W-1:0]      rem_h_ff, rem_h_in, rem_l_ff, rem_l_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic                  hold_bit_ff, hold_bit_in;
   logic [FOLLOW_W-1:0]   hold_follow_ff, hold_follow_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_bit_ff, out_bit_in;
   logic [FOLLOW_W-1:0]   out_follow_ff, out_follow_in;
   logic                  out_last_ff, out_last_in;

   logic [RANGE_W-1:0]    range_w;
   logic [DIVIDEND_W-1:0] prod_h, prod_l;
   logic [REM_W:0]        trial_h, trial_l, scale_ext;
   logic                  ge_h, ge_l;
   logic                  emit, under;
   logic [FOLLOW_W-1:0]   pend_inc;
   logic [CODE_W-1:0]     low_m, high_m;

   // multiply the range by the high and low counts at accept
   assign range_w = {1'b0, high_ff - low_ff} + RANGE_W'(1);
   assign prod_h  = DIVIDEND_W'(range_w * req_high_count);
   assign prod_l  = DIVIDEND_W'(range_w * req_low_count);

   // restoring division step, one quotient bit per cycle
   assign scale_ext = {1'b0, scale_ff};
   assign trial_h   = {rem_h_ff, dq_h_ff[DIVIDEND_W-1]};
   assign trial_l   = {rem_l_ff, dq_l_ff[DIVIDEND_W-1]};
   assign ge_h      = trial_h >= scale_ext;
   assign ge_l      = trial_l >= scale_ext;

   assign emit  = high_ff[CODE_MSB] == low_ff[CODE_MSB];
   assign under = !emit && low_ff[UNDER_BIT] && !high_ff[UNDER_BIT];

   assign pend_inc = (pend_ff == FOLLOW_MAX) ? FOLLOW_MAX : pend_ff + FOLLOW_W'(1);
   assign low_m    = under ? (low_ff & ~UNDER_MASK) : low_ff;
   assign high_m   = under ? (high_ff | UNDER_MASK) : high_ff;

   always_comb begin
      scale_in       = csr_write_enable ? csr_write_data : scale_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      pend_in        = pend_ff;
      dq_h_in        = dq_h_ff;
      dq_l_in        = dq_l_ff;
      rem_h_in       = rem_h_ff;
      rem_l_in       = rem_l_ff;
      cnt_in         = cnt_ff;
      hold_valid_in  = hold_valid_ff;
      hold_bit_in    = hold_bit_ff;
      hold_follow_in = hold_follow_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_bit_in     = out_bit_ff;
      out_follow_in  = out_follow_ff;
      out_last_in    = out_last_ff;

      if (cmd.mul_load) begin
         dq_h_in  = prod_h;
         dq_l_in  = prod_l;
         rem_h_in = '0;
         rem_l_in = '0;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         dq_h_in  = {dq_h_ff[DIVIDEND_W-2:0], ge_h};
         dq_l_in  = {dq_l_ff[DIVIDEND_W-2:0], ge_l};
         rem_h_in = ge_h ? REM_W'(trial_h - scale_ext) : trial_h[REM_W-1:0];
         rem_l_in = ge_l ? REM_W'(trial_l - scale_ext) : trial_l[REM_W-1:0];
         cnt_in   = cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.bounds_load) begin
         high_in = low_ff + dq_h_ff[CODE_W-1:0] - CODE_W'(1);
         low_in  = low_ff + dq_l_ff[CODE_W-1:0];
      end
      if (cmd.out_push) begin
         out_valid_in  = 1'b1;
         out_bit_in    = hold_bit_ff;
         out_follow_in = hold_follow_ff;
         out_last_in   = cmd.out_last;
         hold_valid_in = 1'b0;
      end
      if (cmd.ren_step) begin
         if (emit) begin
            hold_valid_in  = 1'b1;
            hold_bit_in    = high_ff[CODE_MSB];
            hold_follow_in = pend_ff;
            pend_in        = '0;
         end else begin
            pend_in = pend_inc;
         end
         low_in  = {low_m[CODE_W-2:0], 1'b0};
         high_in = {high_m[CODE_W-2:0], 1'b1};
      end
      if (cmd.flush_load) begin
         hold_valid_in  = 1'b1;
         hold_bit_in    = low_ff[UNDER_BIT];
         hold_follow_in = pend_inc;
         low_in         = LOW_RESET;
         high_in        = HIGH_RESET;
         pend_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SCALE_RESET;
         low_ff        <= LOW_RESET;
         high_ff       <= HIGH_RESET;
         pend_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         scale_ff      <= scale_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         pend_ff       <= pend_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_h_ff        <= dq_h_in;
      dq_l_ff        <= dq_l_in;
      rem_h_ff       <= rem_h_in;
      rem_l_ff       <= rem_l_in;
      cnt_ff         <= cnt_in;
      hold_bit_ff    <= hold_bit_in;
      hold_follow_ff <= hold_follow_in;
      out_bit_ff     <= out_bit_in;
      out_follow_ff  <= out_follow_in;
      out_last_ff    <= out_last_in;
   end

   always_comb begin
      status.scale_zero = scale_ff == '0;
      status.div_last   = cnt_ff == DIV_LAST_CNT;
      status.ren_emit   = emit;
      status.ren_under  = under;
      status.hold_valid = hold_valid_ff;
      status.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_bit     = out_bit_ff;
   assign rsp_follow_count = out_follow_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

[bench/testbench.sv]
// self-checking testbench for the 16-bit arithmetic range encoder
`timescale 1ns / 100ps

import are_pkg::*;

typedef struct {
   logic                code_bit;
   logic [FOLLOW_W-1:0] follow_count;
   logic                last;
} code_word_type;

class range_coder_tracker;
   localparam logic [CODE_W-1:0] MID_POINT = 16'h8000;
   localparam int MAX_WORDS  = 16;
   localparam int MAX_SHIFTS = 32;

   logic [SCALE_W-1:0]  scale;
   logic [CODE_W-1:0]   low_bound;
   logic [CODE_W-1:0]   high_bound;
   logic [FOLLOW_W-1:0] pend_run;
   code_word_type       owed_words[$];
   int                  failures;

   function new();
      scale = SCALE_RESET;
      failures = 0;
      restart();
   endfunction

   function void restart();
      low_bound = LOW_RESET;
      high_bound = HIGH_RESET;
      pend_run = '0;
   endfunction

   // symbol sub-interval before renormalization, wrapping at 16 bits
   function void narrow(input logic [COUNT_W-1:0] lc, input logic [COUNT_W-1:0] hc,
                        output logic [CODE_W-1:0] nlo, output logic [CODE_W-1:0] nhi);
      logic [31:0] span;
      logic [31:0] qh;
      logic [31:0] ql;
      span = {16'd0, high_bound - low_bound} + 32'd1;
      qh = (span * {18'd0, hc}) / {18'd0, scale};
      ql = (span * {18'd0, lc}) / {18'd0, scale};
      nhi = low_bound + qh[CODE_W-1:0] - 16'd1;
      nlo = low_bound + ql[CODE_W-1:0];
   endfunction

   function void accept_symbol(input logic kind, input logic [COUNT_W-1:0] lc,
                               input logic [COUNT_W-1:0] hc);
      code_word_type     w;
      logic [CODE_W-1:0] nlo;
      logic [CODE_W-1:0] nhi;
      int                emitted;
      int                step;
      emitted = 0;
      if (kind == KIND_FLUSH) begin
         w.code_bit = low_bound[UNDER_BIT];
         w.follow_count = (pend_run == FOLLOW_MAX) ? FOLLOW_MAX
                                                   : pend_run + 16'd1;
         w.last = 1'b1;
         owed_words.push_back(w);
         restart();
         return;
      end
      if (scale == '0) return;
      narrow(lc, hc, nlo, nhi);
      low_bound = nlo;
      high_bound = nhi;
      for (step = 0; step < MAX_SHIFTS; step++) begin
         if (low_bound[CODE_MSB] == high_bound[CODE_MSB]) begin
            if (emitted < MAX_WORDS) begin
               w.code_bit = high_bound[CODE_MSB];
               w.follow_count = pend_run;
               w.last = 1'b0;
               owed_words.push_back(w);
               emitted++;
            end
            pend_run = '0;
         end else if (low_bound[UNDER_BIT] && !high_bound[UNDER_BIT]) begin
            if (pend_run != FOLLOW_MAX) pend_run++;
            low_bound[UNDER_BIT] = 1'b0;
            high_bound[UNDER_BIT] = 1'b1;
         end else begin
            break;
         end
         low_bound = low_bound << 1;
         high_bound = {high_bound[CODE_MSB-1:0], 1'b1};
      end
      if (emitted > 0) begin
         w = owed_words.pop_back();
         w.last = 1'b1;
         owed_words.push_back(w);
      end
   endfunction

   function void check_code_word(input logic code_bit, input logic [FOLLOW_W-1:0] follow,
                                 input logic last);
      code_word_type w;
      if (owed_words.size() == 0) begin
         $error("code word with none owed: code_bit %0d follow_count %0d last %0d",
                code_bit, follow, last);
         failures++;
         return;
      end
      w = owed_words.pop_front();
      if (code_bit !== w.code_bit) begin
         $error("code_bit: expected %0d, got %0d", w.code_bit, code_bit);
         failures++;
      end
      if (follow !== w.follow_count) begin
         $error("follow_count: expected %0d, got %0d", w.follow_count, follow);
         failures++;
      end
      if (last !== w.last) begin
         $error("last: expected %0d, got %0d", w.last, last);
         failures++;
      end
   endfunction

   // symbol whose sub-interval straddles the midpoint, to pile up underflow bits
   function void center_symbol(output logic [COUNT_W-1:0] lc, output logic [COUNT_W-1:0] hc);
      logic [CODE_W-1:0] nlo;
      logic [CODE_W-1:0] nhi;
      int unsigned       est;
      int                width;
      int                c;
      est = ((32'(MID_POINT) - 32'(low_bound)) * 32'(scale))
            / (32'(high_bound) - 32'(low_bound) + 32'd1);
      lc = COUNT_W'(est);
      hc = COUNT_W'(est + 1);
      for (width = 1; width <= 2; width++) begin
         for (c = int'(est) - 4; c <= int'(est) + 4; c++) begin
            narrow(COUNT_W'(c), COUNT_W'(c + width), nlo, nhi);
            if (nlo < MID_POINT && nhi >= MID_POINT) begin
               lc = COUNT_W'(c);
               hc = COUNT_W'(c + width);
               return;
            end
         end
      end
   endfunction
endclass

module testbench;
   localparam int HALF_PERIOD    = 10;
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 400;
   localparam int STRADDLE_ITEMS = 40;
   localparam int COUNT_TOP      = (1 << COUNT_W) - 1;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [SCALE_W-1:0]  csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic                req_kind         = KIND_ENCODE;
   logic [COUNT_W-1:0]  req_low_count    = '0;
   logic [COUNT_W-1:0]  req_high_count   = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic                rsp_code_bit;
   logic [FOLLOW_W-1:0] rsp_follow_count;
   logic                rsp_last;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;

   range_coder_tracker coder;

   arithmetic_range_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_low_count    (req_low_count),
      .req_high_count   (req_high_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_bit     (rsp_code_bit),
      .rsp_follow_count (rsp_follow_count),
      .rsp_last         (rsp_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         coder.accept_symbol(req_kind, req_low_count, req_high_count);
      if (!reset && rsp_valid && rsp_ready)
         coder.check_code_word(rsp_code_bit, rsp_follow_count, rsp_last);
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_word(input logic kind, input logic [COUNT_W-1:0] lc,
                            input logic [COUNT_W-1:0] hc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_low_count <= lc;
      req_high_count <= hc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (coder.owed_words.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic set_scale(input logic [SCALE_W-1:0] value);
      wait_idle(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      coder.scale = value;
   endtask

   task automatic send_random_word();
      int unsigned roll;
      int unsigned top;
      int unsigned lc;
      int unsigned hc;
      roll = $urandom_range(99);
      top = coder.scale;
      if (roll < 8) begin
         send_word(KIND_FLUSH, COUNT_W'($urandom_range(COUNT_TOP)),
                   COUNT_W'($urandom_range(COUNT_TOP)));
      end else if (roll < 18 || top == 0) begin
         send_word(KIND_ENCODE, COUNT_W'($urandom_range(COUNT_TOP)),
                   COUNT_W'($urandom_range(COUNT_TOP)));
      end else begin
         lc = $urandom_range(top - 1);
         if (roll < 59)
            hc = $urandom_range(top, lc + 1);
         else
            hc = lc + 1 + $urandom_range((top - lc - 1 > 7) ? 7 : top - lc - 1);
         send_word(KIND_ENCODE, COUNT_W'(lc), COUNT_W'(hc));
      end
   endtask

   task automatic build_underflow(input int count);
      logic [COUNT_W-1:0] lc;
      logic [COUNT_W-1:0] hc;
      int                 k;
      for (k = 0; k < count; k++) begin
         coder.center_symbol(lc, hc);
         send_word(KIND_ENCODE, lc, hc);
      end
   endtask

   initial begin
      #60_000_000;
      $display("arithmetic_range_encoder: mismatch");
      $finish;
   end

   initial begin
      int                 seg;
      int                 n;
      int                 items;
      logic [SCALE_W-1:0] seg_scale;
      coder = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 72;
      set_scale(SCALE_RESET);
      send_word(KIND_ENCODE, 14'd0, 14'd16383);
      send_word(KIND_ENCODE, 14'd0, 14'd1);
      send_word(KIND_ENCODE, 14'd16382, 14'd16383);
      send_word(KIND_ENCODE, 14'd8191, 14'd8192);
      send_word(KIND_FLUSH, 14'd0, 14'd0);
      send_word(KIND_FLUSH, 14'd16383, 14'd16383);
      send_word(KIND_ENCODE, 14'd16383, 14'd0);
      send_word(KIND_ENCODE, 14'd5000, 14'd5000);
      send_word(KIND_ENCODE, 14'd12000, 14'd3000);
      send_word(KIND_FLUSH, 14'd10922, 14'd5461);

      set_scale(14'd1);
      send_word(KIND_ENCODE, 14'd0, 14'd1);
      send_word(KIND_ENCODE, 14'd0, 14'd0);
      send_word(KIND_ENCODE, 14'd1, 14'd16383);
      send_word(KIND_ENCODE, 14'd16383, 14'd16383);
      send_word(KIND_FLUSH, 14'd0, 14'd0);

      // zero scale: encode words are dropped, flush still answers
      set_scale(14'd0);
      send_word(KIND_ENCODE, 14'd0, 14'd1);
      send_word(KIND_ENCODE, 14'd100, 14'd8000);
      send_word(KIND_FLUSH, 14'd0, 14'd0);

      // long run of symbols astride the midpoint, then flush
      set_scale(SCALE_RESET);
      build_underflow(STRADDLE_ITEMS);
      send_word(KIND_FLUSH, 14'd0, 14'd0);

      for (seg = 0; seg < 9; seg++) begin
         case (seg)
            0: seg_scale = SCALE_RESET;
            1: seg_scale = 14'd1;
            2: seg_scale = SCALE_W'($urandom_range(COUNT_TOP, 2));
            3: seg_scale = 14'd8192;
            4: seg_scale = SCALE_W'($urandom_range(64, 2));
            5: seg_scale = 14'd0;
            6: seg_scale = SCALE_RESET;
            7: seg_scale = SCALE_W'($urandom_range(COUNT_TOP, 2));
            default: seg_scale = SCALE_W'($urandom_range(4000, 2));
         endcase
         items = (seg_scale == '0) ? 12 : 60;
         send_idle_pct = (seg < 3) ? 31 : (seg < 6) ? 72 : 0;
         recv_idle_pct = (seg < 3) ? 72 : (seg < 6) ? 31 : 0;
         set_scale(seg_scale);
         for (n = 0; n < items; n++) begin
            if (seg == 0 && n == 10) hold_left = HOLD_CYCLES;
            if (n == 30) wait_idle(0);
            send_random_word();
         end
      end

      wait_idle(SETTLE_CYCLES);
      if (coder.failures == 0)
         $display("arithmetic_range_encoder: match");
      else
         $display("arithmetic_range_encoder: mismatch");
      $finish;
   end
endmodule
